### sv/ssa_pkg.sv
// Shared types, constants and helpers for the swap slot allocator.
`timescale 1ns / 1ps

package ssa_pkg;

    // Port field widths
    localparam int SLOT_W     = 10;
    localparam int SECTOR_W   = 13;
    localparam int COUNT_W    = 11;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    // Free map word geometry (one word per memory row)
    localparam int WORD_W     = 32;
    localparam int WORD_IDX_W = 5;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

    // Request opcodes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } ssa_status_e;

    // Controller to datapath
    typedef struct packed {
        logic        in_ready;
        logic        latch_req;
        logic        clr_wr;
        logic        scan_init;
        logic        scan_next;
        logic        rd_slot;
        logic        take_found;
        logic        set_free;
        logic        load_base;
        logic        emit_xfer;
        logic        emit_single;
        logic        set_status;
        ssa_status_e status_val;
    } ssa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic             clr_last;
        logic [CMD_W-1:0] req_cmd;
        logic             range_ok;
        logic             hit;
        logic             scan_last;
        logic             bit_free;
        logic             k_last;
        logic             out_free;
    } ssa_stat_t;

    typedef struct packed {
        logic                  hit;
        logic [WORD_IDX_W-1:0] idx;
    } ssa_ffs_t;

    // Lowest set bit of a free map word
    function automatic ssa_ffs_t ssa_ffs(input logic [WORD_W-1:0] w);
        ssa_ffs_t r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r.hit = 1'b1;
                r.idx = WORD_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### sv/ssa_ctrl.sv
// Sequencing state machine of the swap slot allocator.
`timescale 1ns / 1ps

module ssa_ctrl
    import ssa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  ssa_stat_t stat,
    output ssa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SLOT_CHK,
        S_BASE,
        S_EMIT,
        S_ONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.req_cmd) inside
                    CMD_ALLOC: begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    CMD_READ, CMD_FREE: begin
                        if (stat.range_ok) begin
                            cmd.rd_slot = 1'b1;
                            state_next  = S_SLOT_CHK;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_BAD;
                            state_next     = S_ONE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (stat.hit) begin
                    cmd.take_found = 1'b1;
                    state_next     = S_BASE;
                end else if (stat.scan_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_FULL;
                    state_next     = S_ONE;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_SLOT_CHK: begin
                if (stat.bit_free) begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_BAD;
                    state_next     = S_ONE;
                end else begin
                    cmd.set_free = 1'b1;
                    if (stat.req_cmd == CMD_READ) begin
                        state_next = S_BASE;
                    end else begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_OK;
                        state_next     = S_ONE;
                    end
                end
            end
            S_BASE: begin
                cmd.load_base = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_xfer = 1'b1;
                    if (stat.k_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ONE: begin
                if (stat.out_free) begin
                    cmd.emit_single = 1'b1;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

endmodule

### sv/ssa_dp.sv
// Datapath of the swap slot allocator: free map memory, scan, sector counter, output register.
`timescale 1ns / 1ps

module ssa_dp
    import ssa_pkg::*;
#(
    parameter int MAX_SLOTS    = 1024,
    parameter int PAGE_SECTORS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssa_cmd_t            cmd,
    output ssa_stat_t           stat,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_slot_index,
    output logic [SECTOR_W-1:0] m_sector,
    output logic                m_is_write,
    output logic                m_last,
    output logic [STATUS_W-1:0] m_status
);

    localparam int ROWS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SL_W  = ROW_W + WORD_IDX_W;
    localparam int SR_W  = (SL_W > SLOT_W) ? SL_W : SLOT_W;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CW    = ((CNT_W > SR_W) ? CNT_W : SR_W) + 6;
    localparam int K_W   = (PAGE_SECTORS > 1) ? $clog2(PAGE_SECTORS) : 1;
    localparam int PW    = SR_W + 7;

    // Free map: one bit per slot, 1 = free
    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] rdata_reg;

    logic                mem_we;
    logic                mem_re;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_W-1:0]    mem_raddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic [ROW_W-1:0]    clr_row_reg;
    logic [ROW_W-1:0]    scan_row_reg;
    logic [ROW_W-1:0]    scan_row_next;
    logic [COUNT_W-1:0]  slot_count_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [SR_W-1:0]     slot_reg;
    ssa_status_e         status_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic [K_W-1:0]      k_reg;

    logic                m_valid_reg;
    logic [SLOT_W-1:0]   m_slot_index_reg;
    logic [SECTOR_W-1:0] m_sector_reg;
    logic                m_is_write_reg;
    logic                m_last_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic [CW-1:0]       n_cw;
    logic [CW-1:0]       row_base;
    logic [CW-1:0]       diff;
    logic [WORD_W:0]     sh;
    logic [WORD_W-1:0]   row_mask;
    ssa_ffs_t            ffs;
    logic                scan_last;
    logic [SL_W-1:0]     found_slot;
    logic [ROW_W-1:0]    slot_row;
    logic [WORD_IDX_W-1:0] slot_bit;
    logic [PW-1:0]       prod;
    logic                k_last;
    logic                out_free;
    logic                is_alloc;

    // Effective slot count
    assign n_cw = (CW'(slot_count_reg) < CW'(MAX_SLOTS)) ? CW'(slot_count_reg) : CW'(MAX_SLOTS);

    // Valid-bit mask of the row under scan
    always_comb begin
        row_base = CW'({scan_row_reg, WORD_IDX_W'(0)});
        diff     = '0;
        sh       = '0;
        row_mask = '0;
        if (n_cw > row_base) begin
            diff = n_cw - row_base;
            if (diff >= CW'(WORD_W)) begin
                row_mask = '1;
            end else begin
                sh       = (WORD_W + 1)'(1) << diff[WORD_IDX_W-1:0];
                row_mask = WORD_W'(sh - (WORD_W + 1)'(1));
            end
        end
    end

    assign scan_last  = (row_base + CW'(WORD_W)) >= n_cw;
    assign ffs        = ssa_ffs(rdata_reg & row_mask);
    assign found_slot = {scan_row_reg, ffs.idx};
    assign slot_row   = slot_reg[SL_W-1:WORD_IDX_W];
    assign slot_bit   = slot_reg[WORD_IDX_W-1:0];
    assign prod       = PW'(slot_reg) * PW'(PAGE_SECTORS);
    assign k_last     = (k_reg == K_W'(PAGE_SECTORS - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign is_alloc   = (cmd_reg == CMD_ALLOC);

    always_comb begin
        scan_row_next = scan_row_reg;
        if (cmd.scan_init) begin
            scan_row_next = '0;
        end else if (cmd.scan_next) begin
            scan_row_next = scan_row_reg + ROW_W'(1);
        end
    end

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_row_reg;
        mem_wdata = '1;
        if (cmd.clr_wr) begin
            mem_we = 1'b1;
        end else if (cmd.take_found) begin
            mem_we    = 1'b1;
            mem_waddr = scan_row_reg;
            mem_wdata = rdata_reg & ~(WORD_W'(1) << ffs.idx);
        end else if (cmd.set_free) begin
            mem_we    = 1'b1;
            mem_waddr = slot_row;
            mem_wdata = rdata_reg | (WORD_W'(1) << slot_bit);
        end
        mem_re    = cmd.scan_init || cmd.scan_next || cmd.rd_slot;
        mem_raddr = cmd.rd_slot ? slot_row : scan_row_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_row_reg    <= '0;
            slot_count_reg <= SLOT_COUNT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clr_wr) begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
            if (cfg_wr_en) begin
                slot_count_reg <= cfg_wr_data;
            end
            if (cmd.emit_xfer || cmd.emit_single) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_row_reg <= scan_row_next;
        if (cmd.latch_req) begin
            cmd_reg  <= s_command;
            slot_reg <= SR_W'(s_slot);
        end else if (cmd.take_found) begin
            slot_reg <= SR_W'(found_slot);
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status_val;
        end
        if (cmd.load_base) begin
            sec_reg <= SECTOR_W'(prod);
            k_reg   <= '0;
        end else if (cmd.emit_xfer) begin
            sec_reg <= sec_reg + SECTOR_W'(1);
            k_reg   <= k_reg + K_W'(1);
        end
        if (cmd.emit_xfer) begin
            m_slot_index_reg <= SLOT_W'(slot_reg);
            m_sector_reg     <= sec_reg;
            m_is_write_reg   <= is_alloc;
            m_last_reg       <= k_last;
            m_status_reg     <= ST_OK;
        end else if (cmd.emit_single) begin
            m_slot_index_reg <= (status_reg == ST_FULL) ? '0 : SLOT_W'(slot_reg);
            m_sector_reg     <= '0;
            m_is_write_reg   <= 1'b0;
            m_last_reg       <= 1'b1;
            m_status_reg     <= status_reg;
        end
    end

    always_comb begin
        stat.clr_last  = (clr_row_reg == ROW_W'(ROWS - 1));
        stat.req_cmd   = cmd_reg;
        stat.range_ok  = CW'(slot_reg) < n_cw;
        stat.hit       = ffs.hit;
        stat.scan_last = scan_last;
        stat.bit_free  = rdata_reg[slot_bit];
        stat.k_last    = k_last;
        stat.out_free  = out_free;
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_index = m_slot_index_reg;
    assign m_sector     = m_sector_reg;
    assign m_is_write   = m_is_write_reg;
    assign m_last       = m_last_reg;
    assign m_status     = m_status_reg;

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_wr, cmd.take_found, cmd.set_free}))
        else $error("free map written from two sources");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_xfer || cmd.emit_single) |-> (!m_valid_reg || m_ready))
        else $error("result loaded over one still held");

    a_take_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_found |-> ffs.hit)
        else $error("slot taken without a free bit in the row");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_next |-> !scan_last)
        else $error("scan advanced past the last row");

endmodule

### sv/swap_slot_allocator.sv
// Top level of the swap slot allocator: first-fit free map with sector address generation.
// Allocation scans the rows from the lowest, 32 slots per row at 1 row/cycle, and takes the lowest free slot.
// One request in flight; results leave one per cycle while m_ready is high, through a single output register.
// Reset: synchronous; afterward the free map is set to all free by a pass of one row per cycle,
// during which s_ready stays low.
`timescale 1ns / 1ps

module swap_slot_allocator
    import ssa_pkg::*;
#(
    parameter int MAX_SLOTS    = 1024,
    parameter int PAGE_SECTORS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    // Request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [SLOT_W-1:0]   s_slot,

    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_slot_index,
    output logic [SECTOR_W-1:0] m_sector,
    output logic                m_is_write,
    output logic                m_last,
    output logic [STATUS_W-1:0] m_status,

    // Slot count register
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data
);

    // Command and status bundles between the sequencer and the datapath
    ssa_cmd_t  cmd;
    ssa_stat_t stat;

    // Sequencer: clears the map after reset, then walks each request through decode and,
    // as its command needs, row scan or slot check, base address computation and emission.
    ssa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: free map memory (one 32-bit word per row, registered read),
    // lowest-free-bit search on the row just read, sector counter and the
    // output register that lets the next request in while a result waits.
    ssa_dp #(
        .MAX_SLOTS    (MAX_SLOTS),
        .PAGE_SECTORS (PAGE_SECTORS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_command    (s_command),
        .s_slot       (s_slot),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot_index (m_slot_index),
        .m_sector     (m_sector),
        .m_is_write   (m_is_write),
        .m_last       (m_last),
        .m_status     (m_status)
    );

    // Take a request only when the sequencer sits idle
    assign s_ready = cmd.in_ready;

endmodule
